// ===== rtl/core/kinematic_bicycle_step_assert.svh =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step: assertion macros
// Checks that follow a condition in the same cycle or in the next cycle.
// ----------------------------------------------------------------------------
`ifndef KINEMATIC_BICYCLE_STEP_ASSERT_SVH
`define KINEMATIC_BICYCLE_STEP_ASSERT_SVH

// consequent must hold in the cycle of the antecedent
`define KBS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kinematic_bicycle_step: check failed");

// consequent must hold in the cycle after the antecedent
`define KBS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kinematic_bicycle_step: check failed");

`endif

// ===== rtl/core/kbs_pkg.sv =====
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared types, constants and helper functions of the bicycle step block.
// ----------------------------------------------------------------------------
`default_nettype none

package kbs_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int CNT_W        = 6;
  localparam int RED_STEPS    = 13;
  localparam int DIV_W        = 36;

  localparam int Q_PI       = 205887;
  localparam int Q_TWO_PI   = 411775;
  localparam int Q_HALF_PI  = 102944;
  localparam int CORDIC_GAIN = 652032874;

  localparam logic [30:0] RST_INV_WB    = 31'd26214;
  localparam logic [16:0] RST_MAX_STEER = 17'd34315;
  localparam logic [30:0] RST_MAX_ACCEL = 31'd327680;
  localparam logic [30:0] RST_MAX_SPEED = 31'd655360;
  localparam logic signed [31:0] RST_X     = -32'sd983040;
  localparam logic signed [31:0] RST_Y     = 32'sd0;
  localparam logic signed [31:0] RST_HEAD  = 32'sd0;
  localparam logic signed [31:0] RST_SPEED = 32'sd0;

  typedef enum logic [2:0] {
    REG_INV_WB      = 3'd0,
    REG_MAX_STEER   = 3'd1,
    REG_MAX_ACCEL   = 3'd2,
    REG_MAX_SPEED   = 3'd3,
    REG_START_X     = 3'd4,
    REG_START_Y     = 3'd5,
    REG_START_HEAD  = 3'd6,
    REG_START_SPEED = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RLD, S_RED, S_CLD, S_COR, S_DLD, S_DIV, S_DFIN, S_MUL, S_WB, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_STEER, PH_OLD, PH_NEW
  } phase_t;

  typedef enum logic [3:0] {
    MOP_VC, MOP_VS, MOP_DX, MOP_DY, MOP_Q, MOP_RATE, MOP_DH, MOP_DV,
    MOP_OVC, MOP_OVS, MOP_OQ, MOP_ORATE
  } mop_t;

  typedef struct packed {
    logic             load_in;
    logic             red_load;
    logic             red_step;
    logic             cor_load;
    logic             cor_step;
    logic             div_load;
    logic             div_step;
    logic             div_fin;
    logic             mul_issue;
    logic             mul_wb;
    logic             load_out;
    phase_t           phase;
    mop_t             mop;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } stat_t;

  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kinematic_bicycle_step.sv =====
// ----------------------------------------------------------------------------
// kinematic_bicycle_step
// Kinematic bicycle model, one forward Euler step per tick transfer.
// ----------------------------------------------------------------------------
// Usage:
//  A tick transfer on in_* carries steering, acceleration and step time.
//  The block clamps the commands, advances position, heading and speed and
//  returns one result transfer on out_* with the new pose, speed, velocity
//  components and yaw rate. A zero step time is taken and gives no result.
//  Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
//  A tick runs three passes of the angle reducer and CORDIC (steering, old
//  and new heading), the bit-serial tan divider after the first pass, 12
//  ops through the single shared multiplier after the other two and a load
//  of the result register. One tick is worked on at a time; in_tready is
//  high only while the sequencer is idle, so no new tick is taken until
//  the last one has been loaded into the output register.
//  Results sit in an output register: a new tick is taken while a result
//  waits, and a finished step waits in S_OUT while that result is not taken.
//  Reset (rst_n low, synchronous) restores the registers to their defaults
//  and loads the pose and speed from the default start values.
// ----------------------------------------------------------------------------
`default_nettype none

module kinematic_bicycle_step (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // steer_cmd[31:0], accel_cmd[63:32], step_time[80:64], zero pad
  input  wire logic [87:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, heading, speed, vel_x, vel_y, yaw_rate; 32 bits each
  output logic [223:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  kbs_pkg::cmd_t      cmd;
  kbs_pkg::stat_t     stat;
  logic [16:0]        step_time;
  logic signed [31:0] pos_x, pos_y, heading, speed, vel_x, vel_y, yaw_rate;
  logic               take_tick, take_zero;

  assign step_time = in_tdata[80:64];
  assign take_tick = in_tvalid && in_tready && (step_time != 17'd0);
  assign take_zero = in_tvalid && in_tready && (step_time == 17'd0);

  kbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .steer_cmd ($signed(in_tdata[31:0])),
    .accel_cmd ($signed(in_tdata[63:32])),
    .step_time (step_time),
    .cmd       (cmd),
    .stat      (stat),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading),
    .speed     (speed),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .yaw_rate  (yaw_rate)
  );

  assign out_tdata = {yaw_rate, vel_y, vel_x, speed, heading, pos_y, pos_x};

`include "kinematic_bicycle_step_assert.svh"

  `KBS_ASSERT_NEXT(a_busy_after_tick, take_tick, !in_tready)
  `KBS_ASSERT_NEXT(a_zero_step_skip, take_zero, in_tready && !$rose(out_tvalid))
  `KBS_ASSERT_SAME(a_result_frees_seq, $rose(out_tvalid), in_tready)

endmodule

`default_nettype wire

// ===== rtl/core/kbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbs_ctrl
// Sequencer: angle reduction, CORDIC, tan division and multiply ops in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  kbs_pkg::stat_t     stat,
  output kbs_pkg::cmd_t      cmd
);

  kbs_pkg::state_t                 state_r, state_nxt;
  kbs_pkg::phase_t                 phase_r, phase_nxt;
  kbs_pkg::mop_t                   mop_r, mop_nxt;
  logic [kbs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kbs_pkg::S_IDLE;
      phase_r     <= kbs_pkg::PH_STEER;
      mop_r       <= kbs_pkg::MOP_VC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mop_r       <= mop_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mop_nxt   = mop_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      kbs_pkg::S_IDLE: begin
        if (in_tvalid && !stat.dt_zero) begin
          state_nxt = kbs_pkg::S_RLD;
          phase_nxt = kbs_pkg::PH_STEER;
        end
      end
      kbs_pkg::S_RLD: begin
        state_nxt = kbs_pkg::S_RED;
        cnt_nxt   = kbs_pkg::CNT_W'(kbs_pkg::RED_STEPS - 1);
      end
      kbs_pkg::S_RED: begin
        if (cnt_r == '0) begin
          state_nxt = kbs_pkg::S_CLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      kbs_pkg::S_CLD: begin
        state_nxt = kbs_pkg::S_COR;
        cnt_nxt   = '0;
      end
      kbs_pkg::S_COR: begin
        if (cnt_r == kbs_pkg::CNT_W'(kbs_pkg::CORDIC_ITERS - 1)) begin
          case (phase_r)
            kbs_pkg::PH_STEER: state_nxt = kbs_pkg::S_DLD;
            kbs_pkg::PH_OLD: begin
              state_nxt = kbs_pkg::S_MUL;
              mop_nxt   = kbs_pkg::MOP_VC;
            end
            default: begin
              state_nxt = kbs_pkg::S_MUL;
              mop_nxt   = kbs_pkg::MOP_OVC;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      kbs_pkg::S_DLD: begin
        state_nxt = kbs_pkg::S_DIV;
        cnt_nxt   = '0;
      end
      kbs_pkg::S_DIV: begin
        if (cnt_r == kbs_pkg::CNT_W'(kbs_pkg::DIV_W - 1)) begin
          state_nxt = kbs_pkg::S_DFIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      kbs_pkg::S_DFIN: begin
        state_nxt = kbs_pkg::S_RLD;
        phase_nxt = kbs_pkg::PH_OLD;
      end
      kbs_pkg::S_MUL: state_nxt = kbs_pkg::S_WB;
      kbs_pkg::S_WB: begin
        if (mop_r == kbs_pkg::MOP_DV) begin
          state_nxt = kbs_pkg::S_RLD;
          phase_nxt = kbs_pkg::PH_NEW;
        end else if (mop_r == kbs_pkg::MOP_ORATE) begin
          state_nxt = kbs_pkg::S_OUT;
        end else begin
          state_nxt = kbs_pkg::S_MUL;
          mop_nxt   = kbs_pkg::mop_t'(mop_r + 1'b1);
        end
      end
      kbs_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = kbs_pkg::S_IDLE;
        end
      end
      default: state_nxt = kbs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.phase     = phase_r;
    cmd.mop       = mop_r;
    cmd.cnt       = cnt_r;
    in_tready     = 1'b0;
    case (state_r)
      kbs_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      kbs_pkg::S_RLD:  cmd.red_load  = 1'b1;
      kbs_pkg::S_RED:  cmd.red_step  = 1'b1;
      kbs_pkg::S_CLD:  cmd.cor_load  = 1'b1;
      kbs_pkg::S_COR:  cmd.cor_step  = 1'b1;
      kbs_pkg::S_DLD:  cmd.div_load  = 1'b1;
      kbs_pkg::S_DIV:  cmd.div_step  = 1'b1;
      kbs_pkg::S_DFIN: cmd.div_fin   = 1'b1;
      kbs_pkg::S_MUL:  cmd.mul_issue = 1'b1;
      kbs_pkg::S_WB:   cmd.mul_wb    = 1'b1;
      kbs_pkg::S_OUT:  cmd.load_out  = out_free;
      default: ;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_tvalid    = out_valid_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kbs_dp.sv =====
// ----------------------------------------------------------------------------
// kbs_dp
// Datapath: config registers, vehicle state, angle reducer, CORDIC,
// tan divider, shared multiplier and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_addr,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic signed [31:0] steer_cmd,
  input  wire logic signed [31:0] accel_cmd,
  input  wire logic [16:0]        step_time,
  input  kbs_pkg::cmd_t           cmd,
  output kbs_pkg::stat_t          stat,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      heading,
  output logic signed [31:0]      speed,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y,
  output logic signed [31:0]      yaw_rate
);

  localparam logic signed [20:0] PI_A     = 21'(kbs_pkg::Q_PI);
  localparam logic signed [20:0] TWO_PI_A = 21'(kbs_pkg::Q_TWO_PI);
  localparam logic signed [20:0] HALF_A   = 21'(kbs_pkg::Q_HALF_PI);

  // configuration
  logic [30:0] inv_wb_r;
  logic [16:0] max_steer_r;
  logic [30:0] max_accel_r;
  logic [30:0] max_speed_r;

  // vehicle state
  logic signed [31:0] x_r, y_r, yaw_r, vel_r;

  // item operands
  logic signed [31:0] steer_r, accel_r;
  logic [16:0]        dt_r;

  // angle reducer and CORDIC
  logic [31:0]        rem_r;
  logic               neg_r, flip_r;
  logic signed [33:0] cx_r, cy_r, cz_r;

  // tan divider
  logic [20:0]        drem_r;
  logic [19:0]        dd_r;
  logic [35:0]        nq_r;
  logic               dneg_r, czero_r, sneg_r;
  logic signed [31:0] tan_r;

  // multiplier and intermediates
  logic signed [67:0] prod_r;
  logic signed [31:0] vc_r, vs_r, q_r, rate_r, vx_r, vy_r, yr_r;

  // result register
  logic signed [31:0] o_x_r, o_y_r, o_h_r, o_v_r, o_vx_r, o_vy_r, o_yr_r;

  // combinational helpers
  logic signed [32:0] steer_w, steer_lim, accel_w, accel_lim;
  logic signed [31:0] steer_c, accel_c, ang;
  logic [32:0]        red_sub;
  logic signed [20:0] r0, r1, r2;
  logic               flip_c;
  logic signed [33:0] xs, ys, atan_w, cos_w, sin_w;
  logic signed [19:0] s16, c16;
  logic [19:0]        s_mag, c_mag;
  logic [20:0]        dsh;
  logic signed [36:0] qsig;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] pp;
  logic signed [31:0] sp, nv;
  logic signed [32:0] spd_lim, nv_w;

  assign stat.dt_zero = (step_time == 17'd0);

  // input clamps
  always_comb begin
    steer_w   = {steer_cmd[31], steer_cmd};
    steer_lim = $signed({16'd0, max_steer_r});
    if (steer_w > steer_lim) begin
      steer_c = steer_lim[31:0];
    end else if (steer_w < -steer_lim) begin
      steer_c = 32'(-steer_lim);
    end else begin
      steer_c = steer_cmd;
    end
    accel_w   = {accel_cmd[31], accel_cmd};
    accel_lim = $signed({2'd0, max_accel_r});
    if (accel_w > accel_lim) begin
      accel_c = accel_lim[31:0];
    end else if (accel_w < -accel_lim) begin
      accel_c = 32'(-accel_lim);
    end else begin
      accel_c = accel_cmd;
    end
  end

  // angle reduction, fold to [-pi/2, pi/2], CORDIC step
  always_comb begin
    ang     = (cmd.phase == kbs_pkg::PH_STEER) ? steer_r : yaw_r;
    red_sub = {1'b0, rem_r} - (33'(kbs_pkg::Q_TWO_PI) << cmd.cnt[3:0]);
    r0      = neg_r ? -$signed({1'b0, rem_r[19:0]}) : $signed({1'b0, rem_r[19:0]});
    if (r0 > PI_A) begin
      r1 = r0 - TWO_PI_A;
    end else if (r0 < -PI_A) begin
      r1 = r0 + TWO_PI_A;
    end else begin
      r1 = r0;
    end
    flip_c = 1'b1;
    if (r1 > HALF_A) begin
      r2 = r1 - PI_A;
    end else if (r1 < -HALF_A) begin
      r2 = r1 + PI_A;
    end else begin
      r2     = r1;
      flip_c = 1'b0;
    end
    xs     = cx_r >>> cmd.cnt[4:0];
    ys     = cy_r >>> cmd.cnt[4:0];
    atan_w = $signed({4'd0, kbs_pkg::atan_val(cmd.cnt[4:0])});
    cos_w  = flip_r ? -cx_r : cx_r;
    sin_w  = flip_r ? -cy_r : cy_r;
  end

  // tan divider helpers
  always_comb begin
    s16   = sin_w[33:14];
    c16   = cos_w[33:14];
    s_mag = s16[19] ? 20'(-s16) : 20'(s16);
    c_mag = c16[19] ? 20'(-c16) : 20'(c16);
    dsh   = {drem_r[19:0], nq_r[35]};
    qsig  = dneg_r ? -$signed({1'b0, nq_r}) : $signed({1'b0, nq_r});
  end

  // shared multiplier operands and post-shift
  always_comb begin
    case (cmd.mop)
      kbs_pkg::MOP_VC, kbs_pkg::MOP_OVC: begin
        mul_a = 34'(vel_r);
        mul_b = cos_w;
      end
      kbs_pkg::MOP_VS, kbs_pkg::MOP_OVS: begin
        mul_a = 34'(vel_r);
        mul_b = sin_w;
      end
      kbs_pkg::MOP_DX: begin
        mul_a = 34'(vc_r);
        mul_b = $signed({17'd0, dt_r});
      end
      kbs_pkg::MOP_DY: begin
        mul_a = 34'(vs_r);
        mul_b = $signed({17'd0, dt_r});
      end
      kbs_pkg::MOP_Q, kbs_pkg::MOP_OQ: begin
        mul_a = 34'(vel_r);
        mul_b = $signed({3'd0, inv_wb_r});
      end
      kbs_pkg::MOP_RATE, kbs_pkg::MOP_ORATE: begin
        mul_a = 34'(q_r);
        mul_b = 34'(tan_r);
      end
      kbs_pkg::MOP_DH: begin
        mul_a = 34'(rate_r);
        mul_b = $signed({17'd0, dt_r});
      end
      kbs_pkg::MOP_DV: begin
        mul_a = 34'(accel_r);
        mul_b = $signed({17'd0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    case (cmd.mop)
      kbs_pkg::MOP_VC, kbs_pkg::MOP_VS, kbs_pkg::MOP_OVC, kbs_pkg::MOP_OVS:
        pp = prod_r >>> 30;
      default:
        pp = prod_r >>> 16;
    endcase
    sp      = kbs_pkg::sat32(pp);
    nv      = kbs_pkg::sat32(68'(vel_r) + 68'(sp));
    nv_w    = {nv[31], nv};
    spd_lim = $signed({2'd0, max_speed_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_wb_r    <= kbs_pkg::RST_INV_WB;
      max_steer_r <= kbs_pkg::RST_MAX_STEER;
      max_accel_r <= kbs_pkg::RST_MAX_ACCEL;
      max_speed_r <= kbs_pkg::RST_MAX_SPEED;
    end else if (cfg_we) begin
      // start values only matter at reset, which reloads their defaults
      case (kbs_pkg::reg_idx_t'(cfg_addr))
        kbs_pkg::REG_INV_WB:    inv_wb_r    <= cfg_wdata[30:0];
        kbs_pkg::REG_MAX_STEER: max_steer_r <= cfg_wdata[16:0];
        kbs_pkg::REG_MAX_ACCEL: max_accel_r <= cfg_wdata[30:0];
        kbs_pkg::REG_MAX_SPEED: max_speed_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // vehicle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= kbs_pkg::RST_X;
      y_r   <= kbs_pkg::RST_Y;
      yaw_r <= kbs_pkg::RST_HEAD;
      vel_r <= kbs_pkg::RST_SPEED;
    end else if (cmd.mul_wb) begin
      case (cmd.mop)
        kbs_pkg::MOP_DX: x_r   <= kbs_pkg::sat32(68'(x_r) + 68'(sp));
        kbs_pkg::MOP_DY: y_r   <= kbs_pkg::sat32(68'(y_r) + 68'(sp));
        kbs_pkg::MOP_DH: yaw_r <= kbs_pkg::sat32(68'(yaw_r) + 68'(sp));
        kbs_pkg::MOP_DV: begin
          if (nv_w > spd_lim) begin
            vel_r <= spd_lim[31:0];
          end else if (nv_w < -spd_lim) begin
            vel_r <= 32'(-spd_lim);
          end else begin
            vel_r <= nv;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      steer_r <= steer_c;
      accel_r <= accel_c;
      dt_r    <= step_time;
    end
    if (cmd.red_load) begin
      neg_r <= ang[31];
      rem_r <= ang[31] ? 32'(-ang) : 32'(ang);
    end
    if (cmd.red_step && !red_sub[32]) begin
      rem_r <= red_sub[31:0];
    end
    if (cmd.cor_load) begin
      flip_r <= flip_c;
      cx_r   <= 34'(kbs_pkg::CORDIC_GAIN);
      cy_r   <= '0;
      cz_r   <= 34'(r2) <<< 14;
    end
    if (cmd.cor_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_w;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_w;
      end
    end
    if (cmd.div_load) begin
      drem_r  <= '0;
      dd_r    <= c_mag;
      nq_r    <= {s_mag, 16'd0};
      dneg_r  <= s16[19] ^ c16[19];
      czero_r <= (c16 == 20'sd0);
      sneg_r  <= s16[19];
    end
    if (cmd.div_step) begin
      if (dsh >= {1'b0, dd_r}) begin
        drem_r <= dsh - {1'b0, dd_r};
        nq_r   <= {nq_r[34:0], 1'b1};
      end else begin
        drem_r <= dsh;
        nq_r   <= {nq_r[34:0], 1'b0};
      end
    end
    if (cmd.div_fin) begin
      if (czero_r) begin
        tan_r <= sneg_r ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        tan_r <= kbs_pkg::sat32(68'(qsig));
      end
    end
    if (cmd.mul_issue) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.mul_wb) begin
      case (cmd.mop)
        kbs_pkg::MOP_VC:    vc_r   <= sp;
        kbs_pkg::MOP_VS:    vs_r   <= sp;
        kbs_pkg::MOP_Q:     q_r    <= sp;
        kbs_pkg::MOP_RATE:  rate_r <= sp;
        kbs_pkg::MOP_OVC:   vx_r   <= sp;
        kbs_pkg::MOP_OVS:   vy_r   <= sp;
        kbs_pkg::MOP_OQ:    q_r    <= sp;
        kbs_pkg::MOP_ORATE: yr_r   <= sp;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      o_x_r  <= x_r;
      o_y_r  <= y_r;
      o_h_r  <= yaw_r;
      o_v_r  <= vel_r;
      o_vx_r <= vx_r;
      o_vy_r <= vy_r;
      o_yr_r <= yr_r;
    end
  end

  assign pos_x    = o_x_r;
  assign pos_y    = o_y_r;
  assign heading  = o_h_r;
  assign speed    = o_v_r;
  assign vel_x    = o_vx_r;
  assign vel_y    = o_vy_r;
  assign yaw_rate = o_yr_r;

endmodule

`default_nettype wire

// ===== bench/tb_kinematic_bicycle_step.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kinematic_bicycle_step
// Drives tick transfers with random stalls on both channels, predicts every
// pose/speed result with a bit-exact fixed-point bicycle model and checks the
// result stream field by field. Registers are rewritten between phases, with
// a reset-value phase first.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_kinematic_bicycle_step;

  localparam int  LAT     = 400;
  localparam longint LIMIT = 3000000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [16:0] step_time;
    logic [31:0] accel_cmd;
    logic [31:0] steer_cmd;
  } tick_t;

  typedef struct {
    longint pos_x, pos_y, heading, speed, vel_x, vel_y, yaw_rate;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  kinematic_bicycle_step uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model copy of registers and vehicle state
  longint m_inv_wb, m_max_steer, m_max_accel, m_max_speed;
  longint m_start[4];
  longint st_x, st_y, st_head, st_vel;

  tick_t  tick_q[$];
  pose_t  pose_q[$];
  int     fail_cnt = 0;
  longint cyc = 0;
  bit     quiet = 0;      // no idling at the end
  bit     hold_rx = 0;    // long receiver hold-off

  function automatic longint sat(longint v);
    return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
  endfunction

  function automatic longint lim(longint v, longint l);
    return v > l ? l : (v < -l ? -l : v);
  endfunction

  function automatic longint s32(logic [31:0] u);
    return longint'(signed'(u));
  endfunction

  function automatic longint atan_k(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  // cos/sin in 2^-30 units; >>> on longint is floor shift
  task automatic rotate(input longint ang, output longint c, output longint s);
    longint r, x, y, z, nx;
    bit flip;
    r = ang % kbs_pkg::Q_TWO_PI;
    x = kbs_pkg::CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (r > kbs_pkg::Q_PI) r -= kbs_pkg::Q_TWO_PI;
    if (r < -kbs_pkg::Q_PI) r += kbs_pkg::Q_TWO_PI;
    if (r > kbs_pkg::Q_HALF_PI) begin
      r -= kbs_pkg::Q_PI;
      flip = 1;
    end else if (r < -kbs_pkg::Q_HALF_PI) begin
      r += kbs_pkg::Q_PI;
      flip = 1;
    end
    z = r * 16384;
    for (int i = 0; i < kbs_pkg::CORDIC_ITERS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_k(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_k(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint yaw_of(longint v, longint t);
    longint q;
    q = sat((v * m_inv_wb) >>> 16);
    return sat((q * t) >>> 16);
  endfunction

  task automatic advance_pose(input tick_t tk);
    longint steer, accel, dt, c, s, c16, s16, t, vc, vs, nv;
    pose_t p;
    steer = lim(s32(tk.steer_cmd), m_max_steer);
    accel = lim(s32(tk.accel_cmd), m_max_accel);
    dt = tk.step_time;
    if (dt == 0) return;
    rotate(steer, c, s);
    c16 = c >>> 14;
    s16 = s >>> 14;
    if (c16 == 0) t = s16 < 0 ? S32_MIN : S32_MAX;
    else t = sat((s16 * 65536) / c16);
    rotate(st_head, c, s);
    vc = sat((st_vel * c) >>> 30);
    vs = sat((st_vel * s) >>> 30);
    st_x = sat(st_x + sat((vc * dt) >>> 16));
    st_y = sat(st_y + sat((vs * dt) >>> 16));
    st_head = sat(st_head + sat((yaw_of(st_vel, t) * dt) >>> 16));
    nv = sat(st_vel + sat((accel * dt) >>> 16));
    st_vel = lim(nv, m_max_speed);
    rotate(st_head, c, s);
    p.pos_x = st_x; p.pos_y = st_y; p.heading = st_head; p.speed = st_vel;
    p.vel_x = sat((st_vel * c) >>> 30);
    p.vel_y = sat((st_vel * s) >>> 30);
    p.yaw_rate = yaw_of(st_vel, t);
    pose_q.push_back(p);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    fail_cnt++;
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cyc);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  int tx_gap = 0;
  int off_cnt = 0;   // transfers put on the bus
  int acc_cnt = 0;   // transfers taken by the block

  // predict on each accepted transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      acc_cnt++;
      advance_pose(tick_t'(in_tdata[80:0]));
    end
  end

  // driver
  always @(negedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && acc_cnt != off_cnt) begin
      // hold the transfer until it is taken
    end else if (tx_gap > 0) begin
      tx_gap = tx_gap - 1;
      in_tvalid <= 1'b0;
    end else if (tick_q.size() != 0) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else begin
        nxt = tick_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {7'b0, nxt};
        off_cnt++;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // monitor
  int rx_gap = 0;
  always @(negedge clk) begin
    if (hold_rx) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pose_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pose_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = pose_q.pop_front();
        if (s32(out_tdata[31:0]) != w.pos_x) report("pos_x", s32(out_tdata[31:0]), w.pos_x);
        if (s32(out_tdata[63:32]) != w.pos_y) report("pos_y", s32(out_tdata[63:32]), w.pos_y);
        if (s32(out_tdata[95:64]) != w.heading)
          report("heading", s32(out_tdata[95:64]), w.heading);
        if (s32(out_tdata[127:96]) != w.speed)
          report("speed", s32(out_tdata[127:96]), w.speed);
        if (s32(out_tdata[159:128]) != w.vel_x)
          report("vel_x", s32(out_tdata[159:128]), w.vel_x);
        if (s32(out_tdata[191:160]) != w.vel_y)
          report("vel_y", s32(out_tdata[191:160]), w.vel_y);
        if (s32(out_tdata[223:192]) != w.yaw_rate)
          report("yaw_rate", s32(out_tdata[223:192]), w.yaw_rate);
      end
    end
  end

  task automatic write_reg(input kbs_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kbs_pkg::REG_INV_WB:      m_inv_wb = val[30:0];
      kbs_pkg::REG_MAX_STEER:   m_max_steer = val[16:0];
      kbs_pkg::REG_MAX_ACCEL:   m_max_accel = val[30:0];
      kbs_pkg::REG_MAX_SPEED:   m_max_speed = val[30:0];
      kbs_pkg::REG_START_X:     m_start[0] = s32(val);
      kbs_pkg::REG_START_Y:     m_start[1] = s32(val);
      kbs_pkg::REG_START_HEAD:  m_start[2] = s32(val);
      kbs_pkg::REG_START_SPEED: m_start[3] = s32(val);
      default: ;
    endcase
  endtask

  task automatic drain;
    wait (tick_q.size() == 0 && !in_tvalid && pose_q.size() == 0);
    repeat (LAT) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  function automatic tick_t rand_tick(bit wild);
    tick_t t;
    case ($urandom_range(0, 9))
      0: t.step_time = 17'd0;
      1: t.step_time = 17'h1ffff - 17'($urandom_range(0, 3));
      2: t.step_time = 17'd65536;
      default: t.step_time = 17'($urandom_range(1, 2000));
    endcase
    if (wild) begin
      t.steer_cmd = rnd32();
      t.accel_cmd = rnd32();
    end else begin
      t.steer_cmd = 32'($signed($urandom_range(0, 200000)) - 100000);
      t.accel_cmd = 32'($signed($urandom_range(0, 800000)) - 400000);
    end
    return t;
  endfunction

  initial begin
    m_inv_wb = kbs_pkg::RST_INV_WB; m_max_steer = kbs_pkg::RST_MAX_STEER;
    m_max_accel = kbs_pkg::RST_MAX_ACCEL; m_max_speed = kbs_pkg::RST_MAX_SPEED;
    m_start = '{kbs_pkg::RST_X, kbs_pkg::RST_Y, kbs_pkg::RST_HEAD, kbs_pkg::RST_SPEED};
    st_x = kbs_pkg::RST_X; st_y = kbs_pkg::RST_Y;
    st_head = kbs_pkg::RST_HEAD; st_vel = kbs_pkg::RST_SPEED;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero step, long step, steering at +-90 deg
    tick_q.push_back('{17'd655, 32'sd131072, 32'sd0});
    tick_q.push_back('{17'd0, 32'sd65536, 32'sd20000});
    tick_q.push_back('{17'd65536, 32'h7fffffff, 32'h7fffffff});
    tick_q.push_back('{17'h1ffff, 32'h80000000, 32'h80000000});
    tick_q.push_back('{17'd1000, 32'sd0, 32'sd102944});
    tick_q.push_back('{17'd1000, 32'sd0, -32'sd102944});
    tick_q.push_back('{17'd1, 32'hffffffff, 32'hffffffff});
    tick_q.push_back('{17'h10000, 32'h55555555, 32'haaaaaaaa});
    tick_q.push_back('{17'h0ffff, 32'haaaaaaaa, 32'h55555555});
    drain();

    // wide steering limit and unbounded speed; watch saturation and cos zero
    write_reg(kbs_pkg::REG_MAX_STEER, 32'h1ffff);
    write_reg(kbs_pkg::REG_MAX_SPEED, 32'h7fffffff);
    write_reg(kbs_pkg::REG_MAX_ACCEL, 32'h7fffffff);
    write_reg(kbs_pkg::REG_INV_WB, 32'h7fffffff);
    for (int i = 0; i < 20; i++) tick_q.push_back(rand_tick(1));
    tick_q.push_back('{17'd1000, 32'sd0, 32'sd102944});
    drain();

    // zero limits and zero inverse wheel base
    write_reg(kbs_pkg::REG_MAX_STEER, 32'd0);
    write_reg(kbs_pkg::REG_MAX_ACCEL, 32'd0);
    write_reg(kbs_pkg::REG_MAX_SPEED, 32'd0);
    write_reg(kbs_pkg::REG_INV_WB, 32'd0);
    for (int i = 0; i < 20; i++) tick_q.push_back(rand_tick(1));
    drain();

    // writes to the start values are ignored by the block, so they must not alter the run
    write_reg(kbs_pkg::REG_START_X, 32'h7fffffff);
    write_reg(kbs_pkg::REG_START_Y, 32'h80000000);
    write_reg(kbs_pkg::REG_START_HEAD, 32'h12345678);
    write_reg(kbs_pkg::REG_START_SPEED, 32'hfff00000);
    write_reg(kbs_pkg::REG_INV_WB, 32'd1);
    write_reg(kbs_pkg::REG_MAX_STEER, 32'd91750);
    write_reg(kbs_pkg::REG_MAX_ACCEL, 32'd327680);
    write_reg(kbs_pkg::REG_MAX_SPEED, 32'd655360);

    // receiver hold-off while ticks keep coming
    hold_rx = 1;
    for (int i = 0; i < 20; i++) tick_q.push_back(rand_tick(0));
    repeat (3000) @(posedge clk);
    hold_rx = 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(kbs_pkg::REG_INV_WB, $urandom_range(1, 200000));
      write_reg(kbs_pkg::REG_MAX_STEER, $urandom_range(0, 91750));
      write_reg(kbs_pkg::REG_MAX_ACCEL, $urandom_range(0, 1000000));
      write_reg(kbs_pkg::REG_MAX_SPEED, $urandom_range(0, 3000000));
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 350; i++) tick_q.push_back(rand_tick($urandom_range(0, 5) == 0));
      drain();
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/kbs_pkg.sv
rtl/core/kbs_ctrl.sv
rtl/core/kbs_dp.sv
rtl/core/kinematic_bicycle_step.sv
bench/tb_kinematic_bicycle_step.sv
